>>> hw/rtl/max_pool_2d_stream_assert.svh
// assertion macros used by the checker file
`ifndef MAX_POOL_2D_STREAM_ASSERT_SVH
`define MAX_POOL_2D_STREAM_ASSERT_SVH

// same-cycle implication, off while in reset
`define MP2D_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off while in reset
`define MP2D_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also covers reset itself
`define MP2D_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hw/rtl/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// shared types and constants of the 2-d max pooling stream block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mp2d_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAX_POOL        = 8;
  localparam int MAX_PLANE_WIDTH = 16;
  localparam int STORE_DEPTH     = MAX_POOL * MAX_PLANE_WIDTH;
  localparam int STORE_AW        = $clog2(STORE_DEPTH);

  localparam logic signed [SAMPLE_BITS-1:0] PAD_VALUE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration register indexes
  localparam logic [2:0] REG_POOL_H   = 3'd0;
  localparam logic [2:0] REG_POOL_W   = 3'd1;
  localparam logic [2:0] REG_STRIDE_H = 3'd2;
  localparam logic [2:0] REG_STRIDE_W = 3'd3;
  localparam logic [2:0] REG_PAD_H    = 3'd4;
  localparam logic [2:0] REG_PAD_W    = 3'd5;
  localparam logic [2:0] REG_PLANE_H  = 3'd6;
  localparam logic [2:0] REG_PLANE_W  = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          plane_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] win_max;
    logic [10:0]                   out_row;
    logic [4:0]                    out_col;
    logic                          run_last;
    logic                          plane_last;
  } out_item_t;

  // divider jobs: last output row, last output column, row range, column range
  typedef enum logic [1:0] {
    JOB_OHL,
    JOB_OWL,
    JOB_ROW,
    JOB_COL
  } div_job_t;

  typedef struct packed {
    logic     accept;
    logic     div_start;
    div_job_t job;
    logic     base;
    logic     issue;
    logic     emit;
    logic     next_col;
    logic     next_row;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic geo_ok;
    logic row_hit;
    logic empty;
    logic elem_last;
    logic col_last;
    logic row_last;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/mp2d_ctrl.sv
// ----------------------------------------------------------------------------
// mp2d_ctrl
// sequencer: takes an item, runs the range divisions, walks the windows
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mp2d_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  mp2d_pkg::sts_t sts,
  output mp2d_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_DRUN,
    S_RANGE,
    S_WIN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  mp2d_pkg::div_job_t job_r, job_nxt;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    cmd       = '0;
    cmd.job   = job_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PLAN;
        end
      end
      S_PLAN: begin
        if (!sts.geo_ok) begin
          job_nxt = mp2d_pkg::JOB_OHL;
        end else if (!sts.row_hit) begin
          job_nxt = mp2d_pkg::JOB_ROW;
        end else begin
          job_nxt = mp2d_pkg::JOB_COL;
        end
        cmd.div_start = 1'b1;
        cmd.job       = job_nxt;
        state_nxt     = S_DRUN;
      end
      S_DRUN: begin
        if (sts.div_last) begin
          case (job_r)
            mp2d_pkg::JOB_OHL: job_nxt = mp2d_pkg::JOB_OWL;
            mp2d_pkg::JOB_OWL: job_nxt = mp2d_pkg::JOB_ROW;
            mp2d_pkg::JOB_ROW: job_nxt = mp2d_pkg::JOB_COL;
            default:           job_nxt = job_r;
          endcase
          if (job_r == mp2d_pkg::JOB_COL) begin
            state_nxt = S_RANGE;
          end else begin
            cmd.div_start = 1'b1;
            cmd.job       = job_nxt;
          end
        end
      end
      S_RANGE: begin
        if (sts.empty) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.base  = 1'b1;
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        cmd.issue = 1'b1;
        if (sts.elem_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (!sts.col_last) begin
            cmd.next_col = 1'b1;
            state_nxt    = S_WIN;
          end else if (!sts.row_last) begin
            cmd.next_row = 1'b1;
            state_nxt    = S_WIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= mp2d_pkg::JOB_OHL;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> hw/rtl/mp2d_dp.sv
// ----------------------------------------------------------------------------
// mp2d_dp
// datapath: config registers, counters, line store, divider, window max
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mp2d_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [10:0]         cfg_wdata,
  input  mp2d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mp2d_pkg::out_item_t out_data,
  input  mp2d_pkg::cmd_t      cmd,
  output mp2d_pkg::sts_t      sts
);

  // raw configuration
  logic [3:0]  kh_raw_r, kw_raw_r, sh_raw_r, sw_raw_r;
  logic [1:0]  ph_raw_r, pw_raw_r;
  logic [10:0] h_raw_r;
  logic [4:0]  w_raw_r;

  // effective configuration
  logic [3:0]  kh, kw, sh, sw;
  logic [1:0]  ph, pw;
  logic [10:0] h;
  logic [4:0]  w;

  always_comb begin
    kh = (kh_raw_r == 4'd0) ? 4'd1 : ((kh_raw_r > 4'd8) ? 4'd8 : kh_raw_r);
    kw = (kw_raw_r == 4'd0) ? 4'd1 : ((kw_raw_r > 4'd8) ? 4'd8 : kw_raw_r);
    sh = (sh_raw_r == 4'd0) ? 4'd1 : sh_raw_r;
    sw = (sw_raw_r == 4'd0) ? 4'd1 : sw_raw_r;
    ph = (ph_raw_r == 2'd3) ? 2'd2 : ph_raw_r;
    pw = (pw_raw_r == 2'd3) ? 2'd2 : pw_raw_r;
    h  = (h_raw_r == 11'd0) ? 11'd1 : ((h_raw_r > 11'd1024) ? 11'd1024 : h_raw_r);
    w  = (w_raw_r == 5'd0) ? 5'd1 : ((w_raw_r > 5'd16) ? 5'd16 : w_raw_r);
  end

  // position counters and the latched position of the current item
  logic [9:0]  row_cnt_r;
  logic [4:0]  col_cnt_r;
  logic [9:0]  r_r;
  logic [3:0]  c_r;
  logic        restart;
  logic [9:0]  r_now;
  logic [3:0]  c_now;
  logic [4:0]  c_inc;
  logic [10:0] r_inc;

  assign restart = in_data.plane_start || ({1'b0, row_cnt_r} >= h) || (col_cnt_r >= w);
  assign r_now   = restart ? 10'd0 : row_cnt_r;
  assign c_now   = restart ? 4'd0 : col_cnt_r[3:0];
  assign c_inc   = {1'b0, c_now} + 5'd1;
  assign r_inc   = {1'b0, r_now} + 11'd1;

  // line store
  logic signed [15:0] mem [mp2d_pkg::STORE_DEPTH];
  logic signed [15:0] mem_q_r;
  logic [mp2d_pkg::STORE_AW-1:0] rd_addr;

  // numerators of the four divisions
  logic signed [11:0] n_ohl, n_row, n_sel_start, n_sel_fin;
  logic signed [6:0]  n_owl, n_col;

  assign n_ohl = $signed({1'b0, h}) + $signed({9'b0, ph, 1'b0}) - $signed({8'b0, kh});
  assign n_row = $signed({2'b0, r_r}) + 12'sd1 + $signed({10'b0, ph})
               - $signed({8'b0, kh});
  assign n_owl = $signed({2'b0, w}) + $signed({4'b0, pw, 1'b0}) - $signed({3'b0, kw});
  assign n_col = $signed({3'b0, c_r}) + 7'sd1 + $signed({5'b0, pw})
               - $signed({3'b0, kw});

  // divider: one quotient bit per cycle
  logic               dv_busy_r;
  mp2d_pkg::div_job_t dj_r;
  logic [10:0]        dv_num_r;
  logic [3:0]         dv_den_r;
  logic [3:0]         dv_k_r;
  logic [10:0]        dv_q_r;
  logic [3:0]         dv_rem_r;
  logic [4:0]         dv_t;
  logic               dv_ge;
  logic [3:0]         rem_step;
  logic [10:0]        q_step;
  logic [10:0]        q_ceil;
  logic               dv_last;
  logic               neg_fin;

  always_comb begin
    case (cmd.job)
      mp2d_pkg::JOB_OHL: n_sel_start = n_ohl;
      mp2d_pkg::JOB_OWL: n_sel_start = 12'(n_owl);
      mp2d_pkg::JOB_ROW: n_sel_start = n_row;
      default:           n_sel_start = 12'(n_col);
    endcase
    case (dj_r)
      mp2d_pkg::JOB_OHL: n_sel_fin = n_ohl;
      mp2d_pkg::JOB_OWL: n_sel_fin = 12'(n_owl);
      mp2d_pkg::JOB_ROW: n_sel_fin = n_row;
      default:           n_sel_fin = 12'(n_col);
    endcase
  end

  always_comb begin
    dv_t     = {dv_rem_r, dv_num_r[dv_k_r]};
    dv_ge    = (dv_t >= {1'b0, dv_den_r});
    rem_step = dv_ge ? 4'(dv_t - {1'b0, dv_den_r}) : dv_t[3:0];
    q_step   = dv_q_r;
    q_step[dv_k_r] = dv_ge;
    q_ceil   = q_step + {10'b0, (rem_step != 4'd0)};
    dv_last  = dv_busy_r && (dv_k_r == 4'd0);
    neg_fin  = n_sel_fin[11];
  end

  // stored division results
  logic        geo_ok_r, rowc_ok_r;
  logic [9:0]  rowc_r;
  logic [10:0] ohl_r, rfl_r, rcl_r;
  logic        ohl_neg_r, rneg_r;
  logic [4:0]  owl_r, cfl_r, ccl_r;
  logic        owl_neg_r, cneg_r;

  // window ranges
  logic        r_bottom, c_right;
  logic [10:0] lo_h, hi_h, hi_h_eff;
  logic [4:0]  lo_w, hi_w, hi_w_eff;
  logic        hneg, wneg;

  always_comb begin
    r_bottom = ({1'b0, r_r} == (h - 11'd1));
    c_right  = ({1'b0, c_r} == (w - 5'd1));
    lo_h     = (r_r == 10'd0) ? 11'd0 : rcl_r;
    hi_h     = r_bottom ? ohl_r : rfl_r;
    hneg     = r_bottom ? 1'b0 : rneg_r;
    hi_h_eff = (hi_h > ohl_r) ? ohl_r : hi_h;
    lo_w     = (c_r == 4'd0) ? 5'd0 : ccl_r;
    hi_w     = c_right ? owl_r : cfl_r;
    wneg     = c_right ? 1'b0 : cneg_r;
    hi_w_eff = (hi_w > owl_r) ? owl_r : hi_w;
  end

  // window walk
  logic [10:0]        oh_r;
  logic [4:0]         ow_r;
  logic [2:0]         i_r, j_r;
  logic signed [11:0] rb_r;
  logic signed [6:0]  cb_r;
  logic signed [15:0] acc_r;
  logic               rd_v_r, rd_pad_r;
  logic [14:0]        prod_h;
  logic [8:0]         prod_w;
  logic signed [11:0] rb_lo;
  logic signed [6:0]  cb_lo;
  logic signed [11:0] rr;
  logic signed [6:0]  cc;
  logic               rr_ok, cc_ok;
  logic               j_end;
  logic signed [15:0] rd_val;

  always_comb begin
    prod_h = lo_h * sh;
    prod_w = lo_w * sw;
    rb_lo  = $signed({1'b0, prod_h[10:0]}) - $signed({10'b0, ph});
    cb_lo  = $signed({1'b0, prod_w[5:0]}) - $signed({5'b0, pw});
    rr     = rb_r + $signed({9'b0, i_r});
    cc     = cb_r + $signed({4'b0, j_r});
    rr_ok  = !rr[11] && (rr[10:0] < h);
    cc_ok  = !cc[6] && ({1'b0, cc[5:0]} < {2'b0, w});
    rd_addr = {rr[2:0], cc[3:0]};
    j_end  = ({1'b0, j_r} == (kw - 4'd1));
    rd_val = rd_pad_r ? mp2d_pkg::PAD_VALUE : mem_q_r;
  end

  // output register
  logic                out_valid_r;
  mp2d_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[{r_now[2:0], c_now}] <= in_data.sample;
    end
    if (cmd.issue) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kh_raw_r    <= 4'd2;
      kw_raw_r    <= 4'd2;
      sh_raw_r    <= 4'd2;
      sw_raw_r    <= 4'd2;
      ph_raw_r    <= 2'd0;
      pw_raw_r    <= 2'd0;
      h_raw_r     <= 11'd16;
      w_raw_r     <= 5'd16;
      row_cnt_r   <= 10'd0;
      col_cnt_r   <= 5'd0;
      dv_busy_r   <= 1'b0;
      geo_ok_r    <= 1'b0;
      rowc_ok_r   <= 1'b0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        geo_ok_r  <= 1'b0;
        rowc_ok_r <= 1'b0;
        case (cfg_index)
          mp2d_pkg::REG_POOL_H:   kh_raw_r <= cfg_wdata[3:0];
          mp2d_pkg::REG_POOL_W:   kw_raw_r <= cfg_wdata[3:0];
          mp2d_pkg::REG_STRIDE_H: sh_raw_r <= cfg_wdata[3:0];
          mp2d_pkg::REG_STRIDE_W: sw_raw_r <= cfg_wdata[3:0];
          mp2d_pkg::REG_PAD_H:    ph_raw_r <= cfg_wdata[1:0];
          mp2d_pkg::REG_PAD_W:    pw_raw_r <= cfg_wdata[1:0];
          mp2d_pkg::REG_PLANE_H:  h_raw_r  <= cfg_wdata;
          mp2d_pkg::REG_PLANE_W:  w_raw_r  <= cfg_wdata[4:0];
          default:                h_raw_r  <= h_raw_r;
        endcase
      end

      if (cmd.accept) begin
        r_r <= r_now;
        c_r <= c_now;
        if (c_inc >= w) begin
          col_cnt_r <= 5'd0;
          row_cnt_r <= (r_inc >= h) ? 10'd0 : r_inc[9:0];
        end else begin
          col_cnt_r <= c_inc;
          row_cnt_r <= r_now;
        end
      end

      // each divider step updates remainder and quotient; the finishing step stores the result of the running job
      if (dv_busy_r) begin
        dv_rem_r <= rem_step;
        dv_q_r   <= q_step;
        dv_k_r   <= dv_k_r - 4'd1;
        if (dv_last) begin
          dv_busy_r <= 1'b0;
          case (dj_r)
            mp2d_pkg::JOB_OHL: begin
              ohl_r     <= q_step;
              ohl_neg_r <= neg_fin;
            end
            mp2d_pkg::JOB_OWL: begin
              owl_r     <= q_step[4:0];
              owl_neg_r <= neg_fin;
              geo_ok_r  <= 1'b1;
            end
            mp2d_pkg::JOB_ROW: begin
              rfl_r     <= q_step;
              rcl_r     <= q_ceil;
              rneg_r    <= neg_fin;
              rowc_r    <= r_r;
              rowc_ok_r <= 1'b1;
            end
            default: begin
              cfl_r  <= q_step[4:0];
              ccl_r  <= q_ceil[4:0];
              cneg_r <= neg_fin;
            end
          endcase
        end
      end
      if (cmd.div_start) begin
        dv_busy_r <= 1'b1;
        dj_r      <= cmd.job;
        dv_num_r  <= n_sel_start[11] ? 11'd0 : n_sel_start[10:0];
        dv_den_r  <= (cmd.job == mp2d_pkg::JOB_OHL || cmd.job == mp2d_pkg::JOB_ROW) ? sh : sw;
        dv_k_r    <= (cmd.job == mp2d_pkg::JOB_OHL || cmd.job == mp2d_pkg::JOB_ROW) ?
                     4'd10 : 4'd4;
        dv_q_r    <= 11'd0;
        dv_rem_r  <= 4'd0;
      end

      // read pipeline and running maximum
      rd_v_r <= cmd.issue;
      if (cmd.issue) begin
        rd_pad_r <= !(rr_ok && cc_ok);
        if (j_end) begin
          j_r <= 3'd0;
          i_r <= i_r + 3'd1;
        end else begin
          j_r <= j_r + 3'd1;
        end
      end
      if (rd_v_r && (rd_val > acc_r)) begin
        acc_r <= rd_val;
      end

      if (cmd.base || cmd.next_col || cmd.next_row) begin
        i_r   <= 3'd0;
        j_r   <= 3'd0;
        acc_r <= mp2d_pkg::PAD_VALUE;
      end
      if (cmd.base) begin
        oh_r <= lo_h;
        ow_r <= lo_w;
        rb_r <= rb_lo;
        cb_r <= cb_lo;
      end
      if (cmd.next_col) begin
        ow_r <= ow_r + 5'd1;
        cb_r <= cb_r + $signed({3'b0, sw});
      end
      if (cmd.next_row) begin
        oh_r <= oh_r + 11'd1;
        rb_r <= rb_r + $signed({8'b0, sh});
        ow_r <= lo_w;
        cb_r <= cb_lo;
      end

      if (cmd.emit) begin
        out_valid_r           <= 1'b1;
        out_data_r.win_max    <= acc_r;
        out_data_r.out_row    <= oh_r;
        out_data_r.out_col    <= ow_r;
        out_data_r.run_last   <= (ow_r == hi_w_eff) && (oh_r == hi_h_eff);
        out_data_r.plane_last <= (ow_r == owl_r) && (oh_r == ohl_r);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.div_last  = dv_last;
    sts.geo_ok    = geo_ok_r;
    sts.row_hit   = rowc_ok_r && (rowc_r == r_r);
    sts.empty     = ohl_neg_r || owl_neg_r || hneg || wneg
                  || (lo_h > hi_h_eff) || (lo_w > hi_w_eff);
    sts.elem_last = ({1'b0, i_r} == (kh - 4'd1)) && j_end;
    sts.col_last  = (ow_r == hi_w_eff);
    sts.row_last  = (oh_r == hi_h_eff);
    sts.out_free  = !out_valid_r || !out_stall;
  end

endmodule

>>> hw/rtl/max_pool_2d_stream.sv
// ----------------------------------------------------------------------------
// max_pool_2d_stream
// 2-d max pooling with stride and padding over a raster sample stream
// ----------------------------------------------------------------------------
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   in_data (sample, plane_start)
// out      output     out_valid/out_stall out_data (max, row, col, run/plane last)
// cfg      input      cfg_we              cfg_index, cfg_wdata
//
// each item runs the range divisions: the column bounds always, the row bounds
// as well when the row changes, and the output extents too after a config write
// (serial divider, one quotient bit per cycle). each window then reads its
// pool_height * pool_width elements through the single line store read port.
// reset is synchronous; the line store holds no reset value.
// out_stall holds the result register; the next item is taken while the last
// result of the previous item still waits.
`timescale 1ns / 1ps

module max_pool_2d_stream (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mp2d_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mp2d_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [10:0]         cfg_wdata
);

  mp2d_pkg::cmd_t cmd;
  mp2d_pkg::sts_t sts;

  mp2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mp2d_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> hw/rtl/mp2d_checker.sv
// ----------------------------------------------------------------------------
// mp2d_checker
// port-level checks of the pooling block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_pool_2d_stream_assert.svh"

module mp2d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input mp2d_pkg::out_item_t out_data
);

  // a result waiting on the far side stays
  `MP2D_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)
  // the plane's last window always closes its run
  `MP2D_ASSERT_IMP(a_plane_run, out_valid && out_data.plane_last, out_data.run_last)
  // more results of the item are still to come, so no new item is taken
  `MP2D_ASSERT_IMP(a_run_busy, out_valid && !out_data.run_last, in_stall)
  // a taken item keeps the block busy on the next cycle
  `MP2D_ASSERT_NXT(a_in_take, in_valid && !in_stall, in_stall)
  // reset empties the result register
  `MP2D_ASSERT_RST(a_rst_out, !rst_n, !out_valid)

endmodule

bind max_pool_2d_stream mp2d_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> sim/tb_max_pool_2d_stream.sv
// ----------------------------------------------------------------------------
// tb_max_pool_2d_stream
// self-checking testbench of the 2-d max pooling stream block: a behavioral
// window-max predictor runs on every accepted item and each result is compared
// in order against it, under random input gaps and output stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_max_pool_2d_stream;

  localparam int CYCLE_LIMIT = 5000000;
  localparam int SETTLE      = 120;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  mp2d_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mp2d_pkg::out_item_t out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = mp2d_pkg::REG_POOL_H;
  logic [10:0] cfg_wdata = '0;

  max_pool_2d_stream u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // shadow of the block: registers, line store and raster position
  logic [10:0]              geo_reg [8];
  logic signed [15:0]       rows_seen [mp2d_pkg::STORE_DEPTH];
  int                       next_row;
  int                       next_col;
  mp2d_pkg::out_item_t      window_max_q [$];

  int fails;
  int cycles;
  int gap_pct;
  int stall_pct;
  int hold_left;
  int item_count;

  function automatic int lim(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // work out every window that this sample completes
  function automatic void pool_windows(logic signed [15:0] smp, logic first);
    int kh, kw, sh, sw, ph, pw, h, w, hp, wp, oh_n, ow_n;
    int r, c, r0, c0, rr, cc, best, v;
    mp2d_pkg::out_item_t res;
    mp2d_pkg::out_item_t burst [$];
    kh = lim(int'(geo_reg[mp2d_pkg::REG_POOL_H]), 1, mp2d_pkg::MAX_POOL);
    kw = lim(int'(geo_reg[mp2d_pkg::REG_POOL_W]), 1, mp2d_pkg::MAX_POOL);
    sh = lim(int'(geo_reg[mp2d_pkg::REG_STRIDE_H]), 1, 15);
    sw = lim(int'(geo_reg[mp2d_pkg::REG_STRIDE_W]), 1, 15);
    ph = lim(int'(geo_reg[mp2d_pkg::REG_PAD_H]), 0, 2);
    pw = lim(int'(geo_reg[mp2d_pkg::REG_PAD_W]), 0, 2);
    h  = lim(int'(geo_reg[mp2d_pkg::REG_PLANE_H]), 1, 1024);
    w  = lim(int'(geo_reg[mp2d_pkg::REG_PLANE_W]), 1, mp2d_pkg::MAX_PLANE_WIDTH);
    hp = h + 2 * ph;
    wp = w + 2 * pw;
    oh_n = 0;
    ow_n = 0;
    r = next_row;
    c = next_col;
    if (first || r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    rows_seen[(r % mp2d_pkg::MAX_POOL) * mp2d_pkg::MAX_PLANE_WIDTH + c] = smp;
    if (hp >= kh && wp >= kw) begin
      oh_n = (hp - kh) / sh + 1;
      ow_n = (wp - kw) / sw + 1;
    end
    for (int oh = 0; oh < oh_n; oh++) begin
      r0 = oh * sh;
      if (lim(r0 + kh - 1 - ph, 0, h - 1) != r) continue;
      for (int ow = 0; ow < ow_n; ow++) begin
        c0 = ow * sw;
        if (lim(c0 + kw - 1 - pw, 0, w - 1) != c) continue;
        best = -32768;
        for (int i = 0; i < kh; i++) begin
          rr = r0 + i - ph;
          for (int j = 0; j < kw; j++) begin
            cc = c0 + j - pw;
            v = -32768;
            if (rr >= 0 && rr < h && cc >= 0 && cc < w)
              v = int'(rows_seen[(rr % mp2d_pkg::MAX_POOL) * mp2d_pkg::MAX_PLANE_WIDTH + cc]);
            if (v > best) best = v;
          end
        end
        res.win_max    = best[15:0];
        res.out_row    = oh[10:0];
        res.out_col    = ow[4:0];
        res.run_last   = 1'b0;
        res.plane_last = (oh == oh_n - 1 && ow == ow_n - 1);
        burst = {burst, res};
      end
    end
    if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
    foreach (burst[k]) window_max_q = {window_max_q, burst[k]};
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_row = r & 10'h3ff;
    next_col = c & 5'h1f;
  endfunction

  // result checker
  always @(posedge clk) begin
    mp2d_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (window_max_q.size() == 0) begin
        $error("unexpected result: win_max %0d row %0d col %0d",
               $signed(out_data.win_max), out_data.out_row, out_data.out_col);
        fails++;
      end else begin
        want = window_max_q.pop_front();
        if (out_data.win_max !== want.win_max) begin
          $error("win_max: expected %0d, got %0d",
                 $signed(want.win_max), $signed(out_data.win_max));
          fails++;
        end
        if (out_data.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, out_data.out_row);
          fails++;
        end
        if (out_data.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, out_data.out_col);
          fails++;
        end
        if (out_data.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_data.run_last);
          fails++;
        end
        if (out_data.plane_last !== want.plane_last) begin
          $error("plane_last: expected %0b, got %0b", want.plane_last, out_data.plane_last);
          fails++;
        end
      end
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(logic signed [15:0] smp, logic first);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample <= smp;
    in_data.plane_start <= first;
    do @(posedge clk); while (in_stall);
    pool_windows(smp, first);
    item_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (window_max_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int value);
    logic [10:0] masked;
    masked = value[10:0];
    case (idx)
      mp2d_pkg::REG_PAD_H, mp2d_pkg::REG_PAD_W: masked = {9'b0, value[1:0]};
      mp2d_pkg::REG_PLANE_H:                    masked = value[10:0];
      mp2d_pkg::REG_PLANE_W:                    masked = {6'b0, value[4:0]};
      default:                                  masked = {7'b0, value[3:0]};
    endcase
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[10:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    geo_reg[idx] = masked;
  endtask

  task automatic set_geometry(int kh, int kw, int sh, int sw, int ph, int pw, int h, int w);
    wait_idle();
    write_reg(mp2d_pkg::REG_POOL_H, kh);
    write_reg(mp2d_pkg::REG_POOL_W, kw);
    write_reg(mp2d_pkg::REG_STRIDE_H, sh);
    write_reg(mp2d_pkg::REG_STRIDE_W, sw);
    write_reg(mp2d_pkg::REG_PAD_H, ph);
    write_reg(mp2d_pkg::REG_PAD_W, pw);
    write_reg(mp2d_pkg::REG_PLANE_H, h);
    write_reg(mp2d_pkg::REG_PLANE_W, w);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  task automatic test_extremes();
    set_geometry(2, 2, 2, 2, 0, 0, 2, 2);
    send_item(16'sh8000, 1'b1);
    send_item(16'sh7fff, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(16'shffff, 1'b0);
  endtask

  task automatic test_padding_burst();
    // bottom and right padding finish several windows on one sample
    set_geometry(3, 3, 1, 1, 2, 2, 2, 3);
    for (int i = 0; i < 6; i++) send_item(rand_sample(), i == 0);
  endtask

  task automatic test_plane_too_small();
    set_geometry(8, 8, 1, 1, 0, 0, 1, 1);
    send_item(16'sh1234, 1'b1);
    send_item(16'sh7fff, 1'b0);
  endtask

  task automatic test_register_limits();
    // zero pool, stride and size, pad of three: one sample gives 25 windows
    set_geometry(0, 0, 0, 0, 3, 3, 0, 0);
    send_item(16'sh5a5a, 1'b1);
    send_item(16'sh8001, 1'b0);
    set_geometry(15, 15, 15, 15, 3, 3, 2047, 31);
    for (int i = 0; i < 3; i++) send_item(rand_sample(), i == 0);
  endtask

  task automatic test_plane_boundaries();
    // next plane with no start flag, then a restart mid plane
    set_geometry(2, 2, 1, 1, 1, 0, 2, 2);
    for (int i = 0; i < 8; i++) send_item(rand_sample(), i == 0);
    send_item(rand_sample(), 1'b0);
    for (int i = 0; i < 4; i++) send_item(rand_sample(), i == 0);
  endtask

  task automatic run_random_planes(int quota, int hold);
    int h, w, n;
    while (item_count < quota) begin
      h = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
      w = $urandom_range(1, 16);
      set_geometry($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                   $urandom_range(1, 8), $urandom_range(0, 2), $urandom_range(0, 2), h, w);
      if (hold > 0) begin
        hold_left = hold;
        hold = 0;
      end
      n = h * w * $urandom_range(1, 2);
      if (n > 60) n = 60;
      if (n > quota - item_count) n = quota - item_count;
      for (int i = 0; i < n; i++) begin
        // mostly whole planes, now and then a restart flag mid plane
        send_item(rand_sample(), i == 0 || $urandom_range(29) == 0);
      end
    end
  endtask

  task automatic test_random_traffic();
    int base;
    base = item_count;
    gap_pct = 0;  stall_pct = 0;
    run_random_planes(base + 40, 0);
    gap_pct = 55; stall_pct = 0;
    run_random_planes(base + 80, 0);
    gap_pct = 0;  stall_pct = 55;
    run_random_planes(base + 120, 0);
    gap_pct = 18; stall_pct = 18;
    run_random_planes(base + 150, 0);
    gap_pct = 0;  stall_pct = 0;
    run_random_planes(base + 180, 400);
  endtask

  initial begin
    fails = 0;
    cycles = 0;
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    item_count = 0;
    next_row = 0;
    next_col = 0;
    geo_reg = '{11'd2, 11'd2, 11'd2, 11'd2, 11'd0, 11'd0, 11'd16, 11'd16};
    foreach (rows_seen[i]) rows_seen[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_padding_burst();
    test_plane_too_small();
    test_register_limits();
    test_plane_boundaries();
    test_random_traffic();
    wait_idle();
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
